// ===== hw/rtl/label_bounding_box_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the label bounding box accumulator
// Each macro expands to one labeled concurrent assertion sampled on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LABEL_BOUNDING_BOX_ACCUMULATOR_DEFINES_SVH
`define LABEL_BOUNDING_BOX_ACCUMULATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LBBA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LBBA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lbba_pkg.sv =====
// ----------------------------------------------------------------------------
// lbba_pkg
// Types and constants shared by the label bounding box accumulator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbba_pkg;

	localparam int LABEL_COUNT = 256;
	localparam int LABEL_W     = $clog2(LABEL_COUNT);
	localparam int MAX_COLS    = 4096;
	localparam int MAX_ROWS    = 4096;
	localparam int POS_W       = 12;
	localparam int WIDTH_W     = 13;
	localparam int COUNT_W     = 25;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Item modes
	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_FRAME = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODATA_LABEL = 1'd1;

	typedef struct packed {
		logic [1:0]         mode;
		logic [LABEL_W-1:0] label;
	} in_item_t;

	typedef struct packed {
		logic               found;
		logic [POS_W-1:0]   box_col_min;
		logic [POS_W-1:0]   box_row_min;
		logic [POS_W-1:0]   box_col_max;
		logic [POS_W-1:0]   box_row_max;
		logic [COUNT_W-1:0] pixel_count;
	} out_item_t;

	// One label table entry
	typedef struct packed {
		logic [POS_W-1:0]   col_min;
		logic [POS_W-1:0]   row_min;
		logic [POS_W-1:0]   col_max;
		logic [POS_W-1:0]   row_max;
		logic [COUNT_W-1:0] count;
	} entry_t;

	// Accepted transaction handed to the label table
	typedef struct packed {
		logic             take;
		in_item_t         item;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
	} tbl_req_t;

	// Label table status back to the top level
	typedef struct packed {
		logic      query_wait;
		out_item_t result;
	} tbl_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lbba_position.sv =====
// ----------------------------------------------------------------------------
// lbba_position
// Raster column and row counters, advanced once per accepted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbba_position (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [1:0]                    mode,
	input  logic [lbba_pkg::WIDTH_W-1:0]  image_width,
	output logic [lbba_pkg::POS_W-1:0]    col,
	output logic [lbba_pkg::POS_W-1:0]    row
);
	import lbba_pkg::*;

	logic [WIDTH_W-1:0] eff_width;
	logic               wrap;
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;

	// Clamp the configured width into 1 .. MAX_COLS
	always_comb begin
		if (image_width == '0) begin
			eff_width = WIDTH_W'(1);
		end else if (image_width > WIDTH_W'(MAX_COLS)) begin
			eff_width = WIDTH_W'(MAX_COLS);
		end else begin
			eff_width = image_width;
		end
	end

	assign wrap = ({1'b0, col_q} + WIDTH_W'(1)) >= eff_width;

	// Advance on pixels, restart on frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			case (mode)
				MODE_PIXEL: begin
					if (wrap) begin
						col_q <= '0;
						if (row_q != POS_W'(MAX_ROWS - 1)) begin
							row_q <= row_q + POS_W'(1);
						end
					end else begin
						col_q <= col_q + POS_W'(1);
					end
				end
				MODE_FRAME: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign col = col_q;
	assign row = row_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lbba_table.sv =====
// ----------------------------------------------------------------------------
// lbba_table
// Per-label valid bits, box and count memory, and the read-modify-write stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbba_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbba_pkg::tbl_req_t            req,
	input  logic [lbba_pkg::LABEL_W-1:0]  nodata_label,
	input  logic                          adv,
	output lbba_pkg::tbl_stat_t           stat
);
	import lbba_pkg::*;

	logic [LABEL_COUNT-1:0] valid_q;
	entry_t                 mem_q [LABEL_COUNT];

	logic               busy_s1;
	logic [1:0]         mode_s1;
	logic [LABEL_W-1:0] label_s1;
	logic [POS_W-1:0]   col_s1;
	logic [POS_W-1:0]   row_s1;
	logic               rec_s1;
	logic               vld_s1;
	logic               byp_s1;
	entry_t             byp_data_s1;
	entry_t             rd_s1;

	entry_t cur;
	entry_t nxt;
	logic   wr_en;
	logic   rec_in;

	assign rec_in = (req.item.label != nodata_label);
	assign wr_en  = busy_s1 && (mode_s1 == MODE_PIXEL) && rec_s1 && adv;

	// Valid marks: set on first recorded pixel, clear all on frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.take) begin
			case (req.item.mode)
				MODE_PIXEL: begin
					if (rec_in) begin
						valid_q[req.item.label] <= 1'b1;
					end
				end
				MODE_FRAME: begin
					valid_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (adv) begin
			busy_s1 <= req.take;
		end
	end

	// Capture the transaction, its position, its valid mark and any bypass
	always_ff @(posedge clk) begin
		if (req.take) begin
			mode_s1     <= req.item.mode;
			label_s1    <= req.item.label;
			col_s1      <= req.col;
			row_s1      <= req.row;
			rec_s1      <= rec_in;
			vld_s1      <= valid_q[req.item.label];
			byp_s1      <= wr_en && (label_s1 == req.item.label);
			byp_data_s1 <= nxt;
		end
	end

	// Label memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[label_s1] <= nxt;
		end
		if (req.take) begin
			rd_s1 <= mem_q[req.item.label];
		end
	end

	assign cur = byp_s1 ? byp_data_s1 : rd_s1;

	// Merge the pixel into the entry
	always_comb begin
		if (!vld_s1) begin
			nxt.col_min = col_s1;
			nxt.col_max = col_s1;
			nxt.row_min = row_s1;
			nxt.row_max = row_s1;
			nxt.count   = COUNT_W'(1);
		end else begin
			nxt.col_min = (col_s1 < cur.col_min) ? col_s1 : cur.col_min;
			nxt.col_max = (col_s1 > cur.col_max) ? col_s1 : cur.col_max;
			nxt.row_min = (row_s1 < cur.row_min) ? row_s1 : cur.row_min;
			nxt.row_max = (row_s1 > cur.row_max) ? row_s1 : cur.row_max;
			nxt.count   = (cur.count == COUNT_MAX) ? cur.count : cur.count + COUNT_W'(1);
		end
	end

	// Query answer
	always_comb begin
		stat.query_wait         = busy_s1 && (mode_s1 == MODE_QUERY);
		stat.result.found       = vld_s1;
		stat.result.box_col_min = vld_s1 ? cur.col_min : '0;
		stat.result.box_row_min = vld_s1 ? cur.row_min : '0;
		stat.result.box_col_max = vld_s1 ? cur.col_max : '0;
		stat.result.box_row_max = vld_s1 ? cur.row_max : '0;
		stat.result.pixel_count = vld_s1 ? cur.count : '0;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/label_bounding_box_accumulator.sv =====
// ----------------------------------------------------------------------------
// label_bounding_box_accumulator
// Per-label bounding box and pixel count over a raster stream of labels.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one transaction per item:
//   a pixel label, a query for one label, or a frame start. Column and row are
//   tracked inside, wrapping at the configured image width.
//   out channel (out_valid/out_ready/out_data) returns one transaction per
//   query: found flag, box and pixel count. Pixels and frame starts return
//   nothing.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes image width
//   (index 0) or the no-data label (index 1); it is always ready.
// Timing:
//   One item per cycle while in_ready is high. The label memory read for a
//   query registers when it is accepted, and the result register loads from
//   it when the table stage advances. Pixel updates are a read-modify-write
//   through that memory with a one-entry bypass, so back-to-back pixels merge.
// Reset and stall:
//   Reset clears all valid marks, the position and the output valid flag, and
//   loads width 4096 and no-data label 255. While a result waits on out_ready
//   a following query is held in the table stage and in_ready drops; pixels
//   and frame starts keep flowing until a second query reaches that stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "label_bounding_box_accumulator_defines.svh"

module label_bounding_box_accumulator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lbba_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lbba_pkg::out_item_t              out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lbba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lbba_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lbba_pkg::*;

	logic [WIDTH_W-1:0] image_width_q;
	logic [LABEL_W-1:0] nodata_label_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic             take;
	logic             adv;
	logic [POS_W-1:0] col;
	logic [POS_W-1:0] row;
	tbl_req_t         req;
	tbl_stat_t        stat;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_W'(4096);
			nodata_label_q <= LABEL_W'(255);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_NODATA_LABEL: nodata_label_q <= cfg_data[LABEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Table stage moves unless a query is blocked by a full output register
	assign adv      = !stat.query_wait || !out_valid_q || out_ready;
	assign in_ready = adv;
	assign take     = in_valid && in_ready;

	lbba_position u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.mode        (in_data.mode),
		.image_width (image_width_q),
		.col         (col),
		.row         (row)
	);

	assign req.take = take;
	assign req.item = in_data;
	assign req.col  = col;
	assign req.row  = row;

	lbba_table u_table (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.nodata_label (nodata_label_q),
		.adv          (adv),
		.stat         (stat)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && stat.query_wait) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stat.query_wait) begin
			out_q <= stat.result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`LBBA_ASSERT_NEXT(a_frame_restart, take && (in_data.mode == MODE_FRAME),
		(col == '0) && (row == '0), "position not cleared after frame start")
	`LBBA_ASSERT_NOW(a_query_blocks, stat.query_wait && out_valid_q && !out_ready,
		!in_ready, "input accepted while a query is blocked")
	`LBBA_ASSERT_NOW(a_not_found_zero, out_valid && !out_data.found,
		(out_data.pixel_count == '0) && (out_data.box_col_max == '0),
		"not-found result carries nonzero fields")
	`LBBA_ASSERT_NOW(a_found_count, out_valid && out_data.found,
		out_data.pixel_count != '0, "found result with zero pixel count")

endmodule

`default_nettype wire

// ===== tb/tb_label_bounding_box_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_label_bounding_box_accumulator
// Self-checking bench for the per-label bounding box accumulator. A scoreboard
// tracks raster position, label boxes and pixel counts for every accepted
// input transaction and checks each query result in order. Stimulus covers a
// directed pass over width and no-data corner cases, random phases under
// several register settings, a long output stall and a one-column run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_label_bounding_box_accumulator;

	import lbba_pkg::*;

	localparam logic [1:0]  MODE_UNUSED     = 2'd3;
	localparam int          RESET_CYCLES    = 11;
	localparam int          SETTLE_CYCLES   = 8;
	localparam int          TAIL_CYCLES     = 16;
	localparam int          HOLD_OFF_CYCLES = 300;
	localparam int          POOL_SIZE       = 6;
	localparam int unsigned CYCLE_LIMIT     = 1000000;

	// Predicts query results from the stream of accepted transactions
	class label_box_scoreboard;
		int unsigned         errors;
		bit                  seen [LABEL_COUNT];
		entry_t              boxes [LABEL_COUNT];
		bit [POS_W-1:0]      col;
		bit [POS_W-1:0]      row;
		bit [WIDTH_W-1:0]    width_reg = 13'd4096;
		bit [LABEL_W-1:0]    nodata_reg = 8'd255;
		out_item_t           expected_q [$];

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		function string show(out_item_t r);
			return $sformatf("found=%0d box=(%0d,%0d)-(%0d,%0d) count=%0d", r.found,
				r.box_col_min, r.box_row_min, r.box_col_max, r.box_row_max, r.pixel_count);
		endfunction

		function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH)
				width_reg = val[WIDTH_W-1:0];
			else if (idx == REG_NODATA_LABEL)
				nodata_reg = val[LABEL_W-1:0];
		endfunction

		function void note_item(in_item_t it);
			out_item_t res;
			int        w;
			case (it.mode)
				MODE_PIXEL: begin
					// Record the label at the current position, then advance
					if (it.label != nodata_reg) begin
						if (!seen[it.label]) begin
							seen[it.label] = 1'b1;
							boxes[it.label].col_min = col;
							boxes[it.label].col_max = col;
							boxes[it.label].row_min = row;
							boxes[it.label].row_max = row;
							boxes[it.label].count   = '0;
						end else begin
							if (col < boxes[it.label].col_min) boxes[it.label].col_min = col;
							if (col > boxes[it.label].col_max) boxes[it.label].col_max = col;
							if (row < boxes[it.label].row_min) boxes[it.label].row_min = row;
							if (row > boxes[it.label].row_max) boxes[it.label].row_max = row;
						end
						if (boxes[it.label].count != COUNT_MAX)
							boxes[it.label].count = boxes[it.label].count + 1'b1;
					end
					if (width_reg == 0)
						w = 1;
					else if (width_reg > MAX_COLS)
						w = MAX_COLS;
					else
						w = int'(width_reg);
					// Wrap the column; the row saturates at the last row
					if (int'(col) + 1 >= w) begin
						col = '0;
						if (int'(row) + 1 < MAX_ROWS)
							row = row + 1'b1;
					end else begin
						col = col + 1'b1;
					end
				end
				MODE_QUERY: begin
					res = '0;
					if (seen[it.label]) begin
						res.found       = 1'b1;
						res.box_col_min = boxes[it.label].col_min;
						res.box_row_min = boxes[it.label].row_min;
						res.box_col_max = boxes[it.label].col_max;
						res.box_row_max = boxes[it.label].row_max;
						res.pixel_count = boxes[it.label].count;
					end
					expected_q.insert(expected_q.size(), res);
				end
				MODE_FRAME: begin
					foreach (seen[i])
						seen[i] = 1'b0;
					col = '0;
					row = '0;
				end
				default: ;
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				report({"result with no query pending: ", show(got)});
				return;
			end
			want = expected_q.pop_front();
			if (got.found !== want.found || got.box_col_min !== want.box_col_min ||
					got.box_row_min !== want.box_row_min ||
					got.box_col_max !== want.box_col_max ||
					got.box_row_max !== want.box_row_max ||
					got.pixel_count !== want.pixel_count)
				report({"query result mismatch: expected ", show(want), " got ", show(got)});
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	out_item_t              out_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	label_box_scoreboard    sb;
	bit                     hold_off_req = 1'b0;
	int unsigned            cycle_count  = 0;
	logic [LABEL_W-1:0]     label_pool [POOL_SIZE];

	label_bounding_box_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check every result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	// Pace out_ready: changing stall patterns plus an on-demand long hold-off
	initial begin : sink_pacing
		int pattern;
		int phase_left;
		pattern    = 0;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end
			if (phase_left == 0) begin
				pattern    = $urandom_range(0, 3);
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			case (pattern)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= (phase_left % 4 != 0);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Offer one transaction and hold it until accepted
	task automatic send_item(input in_item_t it);
		in_data  <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
	endtask

	task automatic push(input logic [1:0] mode, input logic [LABEL_W-1:0] lab);
		in_item_t it;
		it.mode  = mode;
		it.label = lab;
		send_item(it);
	endtask

	// Hold until no query is outstanding, then let the pipeline settle
	task automatic wait_idle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_register(idx, val);
	endtask

	task automatic refresh_pool();
		foreach (label_pool[i])
			label_pool[i] = LABEL_W'($urandom_range(0, LABEL_COUNT - 1));
	endtask

	function automatic in_item_t make_item(int query_pct, bit allow_frame);
		in_item_t it;
		int       r;
		int       pick;
		r = $urandom_range(0, 99);
		if (r < query_pct)
			it.mode = MODE_QUERY;
		else if (allow_frame && r < query_pct + 2)
			it.mode = MODE_FRAME;
		else if (r < query_pct + 4)
			it.mode = MODE_UNUSED;
		else
			it.mode = MODE_PIXEL;
		// Favor a few labels so boxes grow and queries hit
		pick = $urandom_range(0, 9);
		if (pick < 6)
			it.label = label_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (pick < 7)
			it.label = sb.nodata_reg;
		else
			it.label = LABEL_W'($urandom_range(0, LABEL_COUNT - 1));
		return it;
	endfunction

	// Send random transactions in bursts, with idle gaps unless gapless
	task automatic stream_items(input int count, input int query_pct,
			input bit allow_frame, input bit gapless);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left)
				burst = left;
			repeat (burst) begin
				send_item(make_item(query_pct, allow_frame));
				left--;
			end
			gap = gapless ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [WIDTH_W-1:0] width_sel;
		logic [LABEL_W-1:0] nodata_sel;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: unseen label, no-data pixel, unused mode, frame start
		push(MODE_QUERY, 8'd0);
		push(MODE_PIXEL, 8'd0);
		push(MODE_PIXEL, 8'd255);
		push(MODE_PIXEL, 8'd7);
		push(MODE_PIXEL, 8'd0);
		push(MODE_QUERY, 8'd0);
		push(MODE_QUERY, 8'd255);
		push(MODE_QUERY, 8'd7);
		push(MODE_UNUSED, 8'hAA);
		push(MODE_FRAME, 8'd0);
		push(MODE_QUERY, 8'd0);
		push(MODE_PIXEL, 8'd1);
		push(MODE_PIXEL, 8'd1);
		push(MODE_PIXEL, 8'd1);
		in_valid <= 1'b0;

		// Shrink the width while the column is already past it
		write_register(REG_IMAGE_WIDTH, 13'd2);
		push(MODE_PIXEL, 8'd1);
		push(MODE_PIXEL, 8'd1);
		push(MODE_PIXEL, 8'd1);
		push(MODE_QUERY, 8'd1);
		in_valid <= 1'b0;

		// Width of zero acts as one column
		write_register(REG_IMAGE_WIDTH, 13'd0);
		push(MODE_PIXEL, 8'd2);
		push(MODE_PIXEL, 8'd2);
		push(MODE_QUERY, 8'd2);
		in_valid <= 1'b0;

		// Oversized width clamps; label zero becomes no-data, 255 becomes real
		write_register(REG_IMAGE_WIDTH, 13'h1FFF);
		write_register(REG_NODATA_LABEL, 13'd0);
		push(MODE_PIXEL, 8'd0);
		push(MODE_QUERY, 8'd0);
		push(MODE_PIXEL, 8'd255);
		push(MODE_QUERY, 8'd255);
		in_valid <= 1'b0;

		// Random phases under a spread of register settings
		for (int p = 0; p < 9; p++) begin
			case (p)
				0:       width_sel = 13'd1;
				1:       width_sel = 13'd2;
				2:       width_sel = 13'd3;
				3:       width_sel = WIDTH_W'($urandom_range(4, 20));
				4:       width_sel = 13'd4096;
				5:       width_sel = 13'h1FFF;
				6:       width_sel = 13'd0;
				7:       width_sel = WIDTH_W'($urandom_range(21, 300));
				default: width_sel = WIDTH_W'($urandom_range(0, 8191));
			endcase
			case (p % 3)
				0:       nodata_sel = 8'd0;
				1:       nodata_sel = 8'd255;
				default: nodata_sel = LABEL_W'($urandom_range(0, 255));
			endcase
			write_register(REG_IMAGE_WIDTH, width_sel);
			write_register(REG_NODATA_LABEL, {5'($urandom_range(0, 31)), nodata_sel});
			refresh_pool();
			if ($urandom_range(0, 1))
				push(MODE_FRAME, LABEL_W'($urandom_range(0, 255)));
			stream_items(130, $urandom_range(8, 35), 1'b1, (p % 3 == 1));
		end

		// Long output stall with a query-heavy stream to back up the input
		hold_off_req = 1'b1;
		stream_items(150, 60, 1'b1, 1'b1);
		wait_idle();

		// Short one-column frame: every pixel wraps to the next row
		write_register(REG_IMAGE_WIDTH, 13'd1);
		write_register(REG_NODATA_LABEL, 13'd255);
		refresh_pool();
		push(MODE_FRAME, 8'd0);
		stream_items(20, 5, 1'b0, 1'b0);

		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== label_bounding_box_accumulator.f =====
+incdir+hw/rtl
hw/rtl/lbba_pkg.sv
hw/rtl/lbba_position.sv
hw/rtl/lbba_table.sv
hw/rtl/label_bounding_box_accumulator.sv
tb/tb_label_bounding_box_accumulator.sv
